### rtl/clipped_line_pixel_generator_top_assert.svh
// Assertion macros for the clipped line pixel generator.
`ifndef CLIPPED_LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define CLIPPED_LINE_PIXEL_GENERATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define CLPG_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CLPG_ASSERT_NEVER(label, clk, rst, expr, msg) \
  `CLPG_ASSERT(label, clk, rst, !(expr), msg)
`else
`define CLPG_ASSERT(label, clk, rst, prop, msg)
`define CLPG_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

### rtl/clpg_pkg.sv
// Shared types and constants for the clipped line pixel generator.
`default_nettype none

package clpg_pkg;

  // Parameter defaults
  localparam int MAX_DIM_DEF    = 64;
  localparam int COORD_BITS_DEF = 12;

  // Fixed field widths
  localparam int CANVAS_BITS    = 7;
  localparam int COLOR_BITS     = 32;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;

  // Hard cap on writes per line
  localparam int MAX_RESULTS    = 64;

  // Register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CANVAS_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DRAW_COLOR    = 2'd2;

  // Register reset values
  localparam logic [CANVAS_BITS-1:0] CANVAS_WIDTH_RST  = 7'd64;
  localparam logic [CANVAS_BITS-1:0] CANVAS_HEIGHT_RST = 7'd64;
  localparam logic [COLOR_BITS-1:0]  DRAW_COLOR_RST    = 32'hFF00_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AXIS,
    ST_ORDER,
    ST_STEP,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

### rtl/clpg_ifs.sv
// Valid/ready channel interfaces: line segments in, pixel writes out.
`default_nettype none

interface clpg_line_if #(
  parameter int COORD_BITS = clpg_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface clpg_pixel_if #(
  parameter int MAX_DIM = clpg_pkg::MAX_DIM_DEF
);
  localparam int PIX_BITS  = $clog2(MAX_DIM);
  localparam int ADDR_BITS = 2 * PIX_BITS;

  logic                            valid;
  logic                            ready;
  logic [PIX_BITS-1:0]             pixel_x;
  logic [PIX_BITS-1:0]             pixel_y;
  logic [ADDR_BITS-1:0]            pixel_address;
  logic [clpg_pkg::COLOR_BITS-1:0] pixel_color;
  logic                            last_pixel;

  modport source (output valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
                  output ready);
endinterface

`default_nettype wire

### rtl/clipped_line_pixel_generator_top.sv
// Clipped Bresenham line pixel generator: top level with sequencer and stepping unit.
`default_nettype none

// Takes one line segment per input beat and emits one framebuffer write beat for
// every Bresenham point that falls inside the canvas (canvas_width x canvas_height,
// each clamped to MAX_DIM), with x, y, address y*width+x, draw_color, and last_pixel
// set on the final write of the line. A line whose start on the major axis is
// negative after ordering draws nothing. A line that writes nothing emits no beat.
// Steps: capture, axis choice and endpoint ordering, then one major-axis step per
// cycle, unless the output stalls, taken by the single shared error/position update
// unit, then the check that sees stepping end, then a flush; a line with a negative
// ordered start returns to idle from the ordering step. Stepping stops as soon as
// the major coordinate passes the line end or the canvas edge, or once the line
// has made MAX_RESULTS writes. A new line is accepted only in idle. Each found
// pixel is held one step back so that the last one can be marked; output
// backpressure stalls stepping only when a new hit meets a held pixel and a full
// output register. Config writes must land only while idle.
module clipped_line_pixel_generator_top #(
  parameter int MAX_DIM    = clpg_pkg::MAX_DIM_DEF,
  parameter int COORD_BITS = clpg_pkg::COORD_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_write,
  input  wire logic [clpg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [clpg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  clpg_line_if.sink                                 line_in,
  clpg_pixel_if.source                              pixel_out
);

  `include "clipped_line_pixel_generator_top_assert.svh"

  // Widths
  localparam int CW        = COORD_BITS + 1;          // signed coordinate / delta
  localparam int EW        = COORD_BITS + 2;          // signed error term
  localparam int DIM_BITS  = $clog2(MAX_DIM + 1);     // clamped canvas size
  localparam int PIX_BITS  = $clog2(MAX_DIM);
  localparam int ADDR_BITS = 2 * PIX_BITS;
  localparam int CMP_W     = ((CW > DIM_BITS) ? CW : DIM_BITS) + 1;
  localparam int CNT_BITS  = $clog2(clpg_pkg::MAX_RESULTS + 1);

  // Config registers
  logic [clpg_pkg::CANVAS_BITS-1:0] canvas_width;
  logic [clpg_pkg::CANVAS_BITS-1:0] canvas_height;
  logic [clpg_pkg::COLOR_BITS-1:0]  draw_color;

  clpg_pkg::state_t state, state_next;

  // Captured endpoints
  logic signed [COORD_BITS-1:0] ax, ay, bx, by;
  // Endpoints mapped to major/minor axis (not yet ordered)
  logic signed [COORD_BITS-1:0] maj_a, maj_b, min_a, min_b;
  logic [DIM_BITS-1:0]          major_lim, minor_lim;
  logic                         steep_flag;

  // Stepping state
  logic signed [CW-1:0] major_pos, major_end, minor_pos;
  logic [CW-1:0]        major_delta, minor_delta;
  logic signed [EW-1:0] step_error;
  logic                 minor_down;
  logic [CNT_BITS-1:0]  pix_count;

  // Held pixel (one behind) and output register
  logic                 pend_valid;
  logic [PIX_BITS-1:0]  pend_x, pend_y;
  logic [ADDR_BITS-1:0] pend_addr;
  logic                 out_valid;
  logic [PIX_BITS-1:0]  out_x, out_y;
  logic [ADDR_BITS-1:0] out_addr;
  logic                 out_last;

  // Clamped canvas
  logic [DIM_BITS-1:0] lim_w, lim_h;
  assign lim_w = (int'(canvas_width) > MAX_DIM) ? DIM_BITS'(MAX_DIM)
                                                : DIM_BITS'(canvas_width);
  assign lim_h = (int'(canvas_height) > MAX_DIM) ? DIM_BITS'(MAX_DIM)
                                                 : DIM_BITS'(canvas_height);

  // ---------------- Axis choice ----------------
  logic signed [CW-1:0] dx, dy;
  logic [CW-1:0]        adx, ady;
  logic                 steep_calc;
  assign dx  = {bx[COORD_BITS-1], bx} - {ax[COORD_BITS-1], ax};
  assign dy  = {by[COORD_BITS-1], by} - {ay[COORD_BITS-1], ay};
  assign adx = dx[CW-1] ? CW'(-dx) : CW'(dx);
  assign ady = dy[CW-1] ? CW'(-dy) : CW'(dy);
  assign steep_calc = ady > adx;

  // ---------------- Endpoint ordering ----------------
  logic                 swap;
  logic signed [CW-1:0] dmaj, dmin;
  logic [CW-1:0]        maj_delta_calc, min_delta_calc;
  logic                 down_calc;
  logic signed [COORD_BITS-1:0] ord_maj_start, ord_maj_end, ord_min_start;
  assign swap  = maj_a > maj_b;
  assign dmaj  = {maj_b[COORD_BITS-1], maj_b} - {maj_a[COORD_BITS-1], maj_a};
  assign dmin  = {min_b[COORD_BITS-1], min_b} - {min_a[COORD_BITS-1], min_a};
  assign maj_delta_calc = dmaj[CW-1] ? CW'(-dmaj) : CW'(dmaj);
  assign min_delta_calc = dmin[CW-1] ? CW'(-dmin) : CW'(dmin);
  // Minor goes down unless the ordered start is strictly below the ordered end.
  assign down_calc = swap ? !dmin[CW-1] : (dmin[CW-1] || (dmin == '0));
  assign ord_maj_start = swap ? maj_b : maj_a;
  assign ord_maj_end   = swap ? maj_a : maj_b;
  assign ord_min_start = swap ? min_b : min_a;

  // ---------------- Shared stepping unit ----------------
  logic signed [CMP_W-1:0] maj_ext, min_ext, maj_lim_ext, min_lim_ext;
  logic                    run, hit;
  logic [PIX_BITS-1:0]     hit_col, hit_row;
  logic [ADDR_BITS-1:0]    hit_addr;
  logic signed [EW-1:0]    err_sub, err_next;
  logic signed [EW-1:0]    minor_delta_ext, major_delta_ext;

  assign maj_ext     = {{(CMP_W-CW){major_pos[CW-1]}}, major_pos};
  assign min_ext     = {{(CMP_W-CW){minor_pos[CW-1]}}, minor_pos};
  assign maj_lim_ext = {{(CMP_W-DIM_BITS){1'b0}}, major_lim};
  assign min_lim_ext = {{(CMP_W-DIM_BITS){1'b0}}, minor_lim};

  assign run = (major_pos <= major_end) && (maj_ext < maj_lim_ext) &&
               (pix_count < CNT_BITS'(clpg_pkg::MAX_RESULTS));
  assign hit = !min_ext[CMP_W-1] && (min_ext < min_lim_ext);

  assign hit_col  = steep_flag ? min_ext[PIX_BITS-1:0] : maj_ext[PIX_BITS-1:0];
  assign hit_row  = steep_flag ? maj_ext[PIX_BITS-1:0] : min_ext[PIX_BITS-1:0];
  assign hit_addr = ADDR_BITS'(hit_row) * ADDR_BITS'(lim_w) + ADDR_BITS'(hit_col);

  assign minor_delta_ext = {{(EW-CW){1'b0}}, minor_delta};
  assign major_delta_ext = {{(EW-CW){1'b0}}, major_delta};
  assign err_sub  = step_error - minor_delta_ext;
  assign err_next = err_sub[EW-1] ? err_sub + major_delta_ext : err_sub;

  // ---------------- Control ----------------
  logic accept, out_free, adv, push_mid, push_last;
  assign accept   = line_in.valid && line_in.ready;
  assign out_free = !out_valid || pixel_out.ready;

  always_comb begin
    state_next = state;
    case (state)
      clpg_pkg::ST_IDLE:  if (accept) state_next = clpg_pkg::ST_AXIS;
      clpg_pkg::ST_AXIS:  state_next = clpg_pkg::ST_ORDER;
      clpg_pkg::ST_ORDER: begin
        // Negative ordered start on the major axis draws nothing.
        state_next = ord_maj_start[COORD_BITS-1] ? clpg_pkg::ST_IDLE : clpg_pkg::ST_STEP;
      end
      clpg_pkg::ST_STEP:  if (!run) state_next = clpg_pkg::ST_FLUSH;
      clpg_pkg::ST_FLUSH: if (!pend_valid || out_free) state_next = clpg_pkg::ST_IDLE;
      default:            state_next = clpg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    line_in.ready = 1'b0;
    adv           = 1'b0;
    push_mid      = 1'b0;
    push_last     = 1'b0;
    case (state)
      clpg_pkg::ST_IDLE:  line_in.ready = 1'b1;
      clpg_pkg::ST_STEP: begin
        // Stall only if a new hit must bump the held pixel into a full output.
        adv      = run && (!hit || !pend_valid || out_free);
        push_mid = run && hit && pend_valid && out_free;
      end
      clpg_pkg::ST_FLUSH: push_last = pend_valid && out_free;
      default: ;
    endcase
  end

  // ---------------- Registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= clpg_pkg::ST_IDLE;
      canvas_width  <= clpg_pkg::CANVAS_WIDTH_RST;
      canvas_height <= clpg_pkg::CANVAS_HEIGHT_RST;
      draw_color    <= clpg_pkg::DRAW_COLOR_RST;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
      pix_count     <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          clpg_pkg::REG_CANVAS_WIDTH:  canvas_width  <= cfg_data[clpg_pkg::CANVAS_BITS-1:0];
          clpg_pkg::REG_CANVAS_HEIGHT: canvas_height <= cfg_data[clpg_pkg::CANVAS_BITS-1:0];
          clpg_pkg::REG_DRAW_COLOR:    draw_color    <= cfg_data[clpg_pkg::COLOR_BITS-1:0];
          default: ;
        endcase
      end
      if (state == clpg_pkg::ST_ORDER) pix_count <= '0;
      if (adv && hit) begin
        pend_valid <= 1'b1;
        pix_count  <= pix_count + 1'b1;
      end else if (push_last) begin
        pend_valid <= 1'b0;
      end
      if (push_mid || push_last) out_valid <= 1'b1;
      else if (pixel_out.ready)  out_valid <= 1'b0;
    end
  end

  // Datapath, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      ax <= line_in.start_x;
      ay <= line_in.start_y;
      bx <= line_in.end_x;
      by <= line_in.end_y;
    end
    if (state == clpg_pkg::ST_AXIS) begin
      steep_flag <= steep_calc;
      maj_a      <= steep_calc ? ay : ax;
      maj_b      <= steep_calc ? by : bx;
      min_a      <= steep_calc ? ax : ay;
      min_b      <= steep_calc ? bx : by;
      major_lim  <= steep_calc ? lim_h : lim_w;
      minor_lim  <= steep_calc ? lim_w : lim_h;
    end
    if (state == clpg_pkg::ST_ORDER) begin
      major_pos   <= {ord_maj_start[COORD_BITS-1], ord_maj_start};
      major_end   <= {ord_maj_end[COORD_BITS-1], ord_maj_end};
      minor_pos   <= {ord_min_start[COORD_BITS-1], ord_min_start};
      major_delta <= maj_delta_calc;
      minor_delta <= min_delta_calc;
      step_error  <= {{(EW-CW+1){1'b0}}, maj_delta_calc[CW-1:1]};
      minor_down  <= down_calc;
    end
    if (adv) begin
      step_error <= err_next;
      major_pos  <= major_pos + CW'(1);
      if (err_sub[EW-1]) minor_pos <= minor_down ? minor_pos - CW'(1) : minor_pos + CW'(1);
      if (hit) begin
        pend_x    <= hit_col;
        pend_y    <= hit_row;
        pend_addr <= hit_addr;
      end
    end
    if (push_mid || push_last) begin
      out_x    <= pend_x;
      out_y    <= pend_y;
      out_addr <= pend_addr;
      out_last <= push_last;
    end
  end

  assign pixel_out.valid         = out_valid;
  assign pixel_out.pixel_x       = out_x;
  assign pixel_out.pixel_y       = out_y;
  assign pixel_out.pixel_address = out_addr;
  assign pixel_out.pixel_color   = draw_color;
  assign pixel_out.last_pixel    = out_last;

  // ---------------- Assertions ----------------
  `CLPG_ASSERT_NEVER(a_idle_no_held_pixel, clk, rst, line_in.ready && pend_valid,
    "held pixel left over when a new line can be taken")
  `CLPG_ASSERT(a_count_cap, clk, rst, pix_count <= CNT_BITS'(clpg_pkg::MAX_RESULTS),
    "pixel count beyond cap")
  `CLPG_ASSERT(a_step_major_nonneg, clk, rst, (state == clpg_pkg::ST_STEP) |-> !major_pos[CW-1],
    "stepping with negative major coordinate")
  `CLPG_ASSERT(a_push_keeps_held, clk, rst, push_mid |=> (pend_valid && out_valid && !out_last),
    "mid-line push lost the held pixel or marked it last")

endmodule

`default_nettype wire

### tb/clipped_line_pixel_generator_top_test.sv
// Self-checking testbench for the clipped Bresenham line pixel generator.
`timescale 1ns / 1ps

module clipped_line_pixel_generator_top_test;

  localparam int COORD_W        = clpg_pkg::COORD_BITS_DEF;
  localparam int MAX_PIX        = clpg_pkg::MAX_DIM_DEF;
  localparam int COLOR_W        = clpg_pkg::COLOR_BITS;
  localparam int CANVAS_W       = clpg_pkg::CANVAS_BITS;
  localparam int IDX_W          = clpg_pkg::CFG_INDEX_BITS;
  localparam int DATA_W         = clpg_pkg::CFG_DATA_BITS;
  // Allowance for a line to pass through the block, pixel-less lines included.
  localparam int SETTLE_CYCLES  = 5 + MAX_PIX + 16;
  // Keep a wide margin over the longest quiet stretch on a correct run.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int NUM_PHASES     = 7;

  // One framebuffer write beat, at the output port widths.
  typedef struct packed {
    logic [5:0]         x;
    logic [5:0]         y;
    logic [11:0]        addr;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_beat_t;

  // Tracks the configuration, traces each accepted line into the pixels it must
  // produce, and matches the pixel beats coming out against them in order.
  class pixel_tracker;
    pixel_beat_t         queued_pixels[$];
    logic [CANVAS_W-1:0] width;
    logic [CANVAS_W-1:0] height;
    logic [COLOR_W-1:0]  color;
    int unsigned         failures;

    function new();
      width    = clpg_pkg::CANVAS_WIDTH_RST;
      height   = clpg_pkg::CANVAS_HEIGHT_RST;
      color    = clpg_pkg::DRAW_COLOR_RST;
      failures = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        clpg_pkg::REG_CANVAS_WIDTH: begin
          width = data[CANVAS_W-1:0];
        end
        clpg_pkg::REG_CANVAS_HEIGHT: begin
          height = data[CANVAS_W-1:0];
        end
        clpg_pkg::REG_DRAW_COLOR: begin
          color = data;
        end
        default: begin
        end
      endcase
    endfunction

    function void trace_line(logic signed [COORD_W-1:0] sx, logic signed [COORD_W-1:0] sy,
                             logic signed [COORD_W-1:0] ex, logic signed [COORD_W-1:0] ey);
      int ax, ay, bx, by, w, h, adx, ady;
      int a_maj, a_min, b_maj, b_min, maj_lim, min_lim, t;
      int pos, mnr, err, dmaj, dmin, n, col, row;
      bit steep, down;
      pixel_beat_t px;
      pixel_beat_t traced[$];
      ax = sx; ay = sy; bx = ex; by = ey;
      w = (width > MAX_PIX) ? MAX_PIX : width;
      h = (height > MAX_PIX) ? MAX_PIX : height;
      adx = (bx > ax) ? bx - ax : ax - bx;
      ady = (by > ay) ? by - ay : ay - by;
      steep = ady > adx;
      if (steep) begin
        a_maj = ay; a_min = ax; b_maj = by; b_min = bx; maj_lim = h; min_lim = w;
      end else begin
        a_maj = ax; a_min = ay; b_maj = bx; b_min = by; maj_lim = w; min_lim = h;
      end
      if (a_maj > b_maj) begin
        t = a_maj; a_maj = b_maj; b_maj = t;
        t = a_min; a_min = b_min; b_min = t;
      end
      dmaj = b_maj - a_maj;
      dmin = (b_min > a_min) ? b_min - a_min : a_min - b_min;
      err  = dmaj / 2;
      down = !(a_min < b_min);
      // negative ordered start on the major axis draws nothing
      if (a_maj < 0) return;
      pos = a_maj;
      mnr = a_min;
      n   = 0;
      while (pos <= b_maj && pos < maj_lim && n < clpg_pkg::MAX_RESULTS) begin
        if (mnr >= 0 && mnr < min_lim) begin
          col = steep ? mnr : pos;
          row = steep ? pos : mnr;
          px.x     = col[5:0];
          px.y     = row[5:0];
          t        = row * w + col;
          px.addr  = t[11:0];
          px.color = color;
          px.last  = 1'b0;
          traced.push_back(px);
          n++;
        end
        err -= dmin;
        if (err < 0) begin
          mnr += down ? -1 : 1;
          err += dmaj;
        end
        pos++;
      end
      if (traced.size() > 0) traced[traced.size()-1].last = 1'b1;
      foreach (traced[k]) queued_pixels.push_back(traced[k]);
    endfunction

    function void report(string what, pixel_beat_t want, pixel_beat_t got);
      failures++;
      if (failures <= 10) begin
        $display("[%0t] %s: expected x=%0d y=%0d addr=%0d color=%h last=%0b",
                 $time, what, want.x, want.y, want.addr, want.color, want.last);
        $display("    got x=%0d y=%0d addr=%0d color=%h last=%0b",
                 got.x, got.y, got.addr, got.color, got.last);
      end
    endfunction

    function void match_pixel(pixel_beat_t got);
      pixel_beat_t want;
      if (queued_pixels.size() == 0) begin
        report("unexpected pixel", '0, got);
        return;
      end
      want = queued_pixels.pop_front();
      if (want !== got) report("pixel mismatch", want, got);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic              cfg_write;
  logic [IDX_W-1:0]  cfg_index;
  logic [DATA_W-1:0] cfg_data;

  clpg_line_if  #(.COORD_BITS(COORD_W)) line_bus ();
  clpg_pixel_if #(.MAX_DIM(MAX_PIX))    pixel_bus ();

  clipped_line_pixel_generator_top #(
    .MAX_DIM    (MAX_PIX),
    .COORD_BITS (COORD_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .line_in   (line_bus),
    .pixel_out (pixel_bus)
  );

  pixel_tracker tracker;
  bit           rx_quiet = 1'b0;   // no output stalls while set
  int unsigned  rx_stall = 0;
  int unsigned  quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idle/stall length: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Output side: ready toggles at the falling edge with random stall runs.
  always @(negedge clk) begin
    if (rx_stall > 0) begin
      pixel_bus.ready <= 1'b0;
      rx_stall        <= rx_stall - 1;
    end else begin
      pixel_bus.ready <= 1'b1;
      if (!rx_quiet) rx_stall <= pick_gap();
    end
  end

  // Every pixel beat is checked against the oldest traced pixel.
  always @(posedge clk) begin
    pixel_beat_t got;
    if (!rst && pixel_bus.valid && pixel_bus.ready) begin
      got = {pixel_bus.pixel_x, pixel_bus.pixel_y, pixel_bus.pixel_address,
             pixel_bus.pixel_color, pixel_bus.last_pixel};
      tracker.match_pixel(got);
    end
  end

  // Watchdog: a run of cycles with no beat on either channel means a hang.
  always @(posedge clk) begin
    if (rst || (line_bus.valid && line_bus.ready) || (pixel_bus.valid && pixel_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d pixels outstanding",
               quiet_cycles, tracker.queued_pixels.size());
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one line at the falling edge and hold it until the block takes it.
  // Valid stays high afterwards; the caller lowers it only for a gap or a drain.
  task automatic send_line(int sx, int sy, int ex, int ey);
    @(negedge clk);
    line_bus.valid   <= 1'b1;
    line_bus.start_x <= sx[COORD_W-1:0];
    line_bus.start_y <= sy[COORD_W-1:0];
    line_bus.end_x   <= ex[COORD_W-1:0];
    line_bus.end_y   <= ey[COORD_W-1:0];
    do @(posedge clk); while (line_bus.ready !== 1'b1);
    tracker.trace_line(sx[COORD_W-1:0], sy[COORD_W-1:0], ex[COORD_W-1:0], ey[COORD_W-1:0]);
  endtask

  task automatic line_gap(bit quiet);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) line_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Stop sending and wait for every traced pixel; optionally let a pixel-less
  // line still in flight finish before touching the registers.
  task automatic drain_pixels(bit settle);
    @(negedge clk) line_bus.valid <= 1'b0;
    while (tracker.queued_pixels.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    tracker.set_reg(idx, data);
  endtask

  // Coordinate around the canvas so most lines land partly inside it.
  function automatic int near_coord(int dim);
    return int'($urandom_range(0, dim + 15)) - 8;
  endfunction

  function automatic int any_coord();
    logic signed [COORD_W-1:0] c;
    c = COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
    return int'(c);
  endfunction

  // Random line: mostly near the canvas, some spanning the full coordinate
  // range, some with one endpoint near and the other far away.
  task automatic random_line(int dim);
    int c[4];
    int r;
    r = $urandom_range(0, 99);
    foreach (c[k]) c[k] = near_coord(dim);
    if (r >= 85) begin
      foreach (c[k]) c[k] = any_coord();
    end else if (r >= 70) begin
      c[2] = any_coord();
      c[3] = any_coord();
    end
    send_line(c[0], c[1], c[2], c[3]);
  endtask

  // Directed lines on the reset 64x64 canvas.
  int dir_lines[24][4] = '{
    '{0, 0, 0, 0},            // single point at origin
    '{40, 20, 40, 20},        // single point inside
    '{0, 0, 63, 0},           // full row
    '{5, 0, 5, 63},           // full column, steep
    '{63, 63, 0, 0},          // diagonal, endpoints reversed
    '{10, 60, 12, 2},         // steep, reversed order
    '{0, 10, 63, 20},         // shallow, minor up
    '{63, 5, 0, 40},          // shallow, reversed, minor down
    '{3, 3, 7, 5},
    '{7, 5, 3, 3},
    '{-5, 10, 20, 10},        // negative start on x major: nothing
    '{10, -5, 10, 20},        // negative start on y major: nothing
    '{-2048, -2048, 2047, 2047},
    '{2047, 2047, -2048, -2048},
    '{0, 0, 2047, 2047},      // runs off the canvas: stops at the edge
    '{0, 0, 2047, 5},
    '{0, -10, 63, 20},        // minor starts below the canvas
    '{0, 70, 63, -5},         // steep; orders to a negative start: nothing
    '{64, 0, 100, 0},         // fully right of canvas
    '{0, 64, 63, 64},         // fully clipped on the minor axis
    '{2047, 0, 2047, 0},
    '{-1, -1, -1, -1},
    '{0, 0, -2048, 0},        // orders to a far negative start
    '{0, 2047, 63, -2048}     // steep, extreme major endpoints: nothing
  };

  initial begin
    int unsigned phase_w[NUM_PHASES];
    int unsigned phase_h[NUM_PHASES];
    logic [COLOR_W-1:0] phase_color[NUM_PHASES];
    int unsigned phase_items[NUM_PHASES];
    int dim;
    bit quiet;

    // All inputs known from time zero.
    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = clpg_pkg::REG_CANVAS_WIDTH;
    cfg_data         = '0;
    line_bus.valid   = 1'b0;
    line_bus.start_x = '0;
    line_bus.start_y = '0;
    line_bus.end_x   = '0;
    line_bus.end_y   = '0;
    pixel_bus.ready  = 1'b0;
    tracker = new();

    // Canvas settings per phase; phase 0 keeps the reset values.
    phase_w = '{64, 1, 64, 127, 0, 37, 13};
    phase_h = '{64, 1, 64, 100, 40, 13, 64};
    phase_color = '{clpg_pkg::DRAW_COLOR_RST, 32'h0000_0000, 32'hFFFF_FFFF,
                    $urandom(), $urandom(), $urandom(), $urandom()};
    phase_items = '{50, 40, 60, 60, 20, 60, 60};

    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        // Registers change only with the block idle. Upper data bits on the
        // canvas registers are junk the block must ignore.
        drain_pixels(1'b1);
        write_reg(clpg_pkg::REG_CANVAS_WIDTH, ($urandom() & 32'hFFFF_FF80) | phase_w[p]);
        write_reg(clpg_pkg::REG_CANVAS_HEIGHT, ($urandom() & 32'hFFFF_FF80) | phase_h[p]);
        write_reg(clpg_pkg::REG_DRAW_COLOR, phase_color[p]);
        @(negedge clk) cfg_write <= 1'b0;
      end
      // One phase runs with no idling on either side.
      quiet    = (p == 2);
      rx_quiet = quiet;
      dim = (phase_w[p] > phase_h[p]) ? phase_w[p] : phase_h[p];
      if (dim > MAX_PIX) dim = MAX_PIX;
      if (dim < 8) dim = 8;

      if (p == 0) begin
        foreach (dir_lines[k]) begin
          send_line(dir_lines[k][0], dir_lines[k][1], dir_lines[k][2], dir_lines[k][3]);
          line_gap(quiet);
        end
      end

      for (int i = 0; i < phase_items[p]; i++) begin
        random_line(dim);
        // Now and then hold the input until the output side has caught up.
        if ((p == 0 && i == 10) || $urandom_range(0, 39) == 0) drain_pixels(1'b0);
        else line_gap(quiet);
      end
    end

    drain_pixels(1'b1);
    if (tracker.queued_pixels.size() != 0)
      $display("%0d expected pixels never arrived", tracker.queued_pixels.size());
    if (tracker.failures == 0 && tracker.queued_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl
rtl/clpg_pkg.sv
rtl/clpg_ifs.sv
rtl/clipped_line_pixel_generator_top.sv
tb/clipped_line_pixel_generator_top_test.sv
